/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/ddmc_pkg.sv */
`timescale 1ns / 1ps

package ddmc_pkg;

   // Request function codes; the three spare codes are ignored.
   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_MOVE   = 3'd1,
      FUNC_TURN   = 3'd2,
      FUNC_LINE   = 3'd3,
      FUNC_SAMPLE = 3'd4
   } func_type;

   // Run mode, one-hot.
   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_MOVE = 4'b0010,
      MODE_TURN = 4'b0100,
      MODE_LINE = 4'b1000
   } mode_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BASE_SPEED      = 3'd0;
   localparam logic [2:0] CSR_LINE_THRESHOLD  = 3'd1;
   localparam logic [2:0] CSR_TURN_SLOWDOWN   = 3'd2;
   localparam logic [2:0] CSR_LINE_CORRECTION = 3'd3;
   localparam logic [2:0] CSR_DRIVE_STEP      = 3'd4;
   localparam logic [2:0] CSR_DISTANCE_RECIP  = 3'd5;
   localparam logic [2:0] CSR_ANGLE_RECIP     = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [7:0]  RST_BASE_SPEED      = 8'd240;
   localparam logic [7:0]  RST_LINE_THRESHOLD  = 8'd215;
   localparam logic [7:0]  RST_TURN_SLOWDOWN   = 8'd80;
   localparam logic [7:0]  RST_LINE_CORRECTION = 8'd5;
   localparam logic [7:0]  RST_DRIVE_STEP      = 8'd5;
   localparam logic [15:0] RST_DISTANCE_RECIP  = 16'd12047;
   localparam logic [15:0] RST_ANGLE_RECIP     = 16'd16024;

   // Bridge nibbles.
   localparam logic [3:0] BRIDGE_STOP    = 4'h0;
   localparam logic [3:0] BRIDGE_FORWARD = 4'h6;

   // Duty arithmetic clamped to the range 0 to 255.
   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : 8'h00;
   endfunction

endpackage

/* rtl/core/differential_drive_motion_controller.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  func, edges, amount, wheel_dirs, levels
// rsp_      out        rsp_valid/rsp_ready  bridge_bits, pwm pair, busy, done, nodes_seen
// csr_      in         csr_valid/csr_ready  csr_index (3 bits), csr_data (16 bits)
//
// One request a cycle is sustained while the response is taken. An accepted request waits
// in the input register, its Q16 target multiply done in front of it; as it moves on, it
// updates the controller state and loads the result register, which holds the response.
// Reset is synchronous and active high; it restores the configuration and state defaults.
// A stalled response holds the result register, and the input register then holds too;
// csr_ready is always high.

module differential_drive_motion_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic        req_left_edge,
   input  logic        req_right_edge,
   input  logic [15:0] req_amount,
   input  logic [3:0]  req_wheel_dirs,
   input  logic [7:0]  req_left_level,
   input  logic [7:0]  req_center_level,
   input  logic [7:0]  req_right_level,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_bridge_bits,
   output logic [7:0]  rsp_left_pwm,
   output logic [7:0]  rsp_right_pwm,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [15:0] rsp_nodes_seen,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // ------------------------------------------------------------------
   // Configuration registers. Writes must arrive only while the controller is
   // idle; the block does not enforce this and orders no writes against requests.
   // ------------------------------------------------------------------
   logic [7:0]  base_speed_ff;
   logic [7:0]  line_threshold_ff;
   logic [7:0]  turn_slowdown_ff;
   logic [7:0]  line_correction_ff;
   logic [7:0]  drive_step_ff;
   logic [15:0] distance_recip_ff;
   logic [15:0] angle_recip_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff      <= ddmc_pkg::RST_BASE_SPEED;
         line_threshold_ff  <= ddmc_pkg::RST_LINE_THRESHOLD;
         turn_slowdown_ff   <= ddmc_pkg::RST_TURN_SLOWDOWN;
         line_correction_ff <= ddmc_pkg::RST_LINE_CORRECTION;
         drive_step_ff      <= ddmc_pkg::RST_DRIVE_STEP;
         distance_recip_ff  <= ddmc_pkg::RST_DISTANCE_RECIP;
         angle_recip_ff     <= ddmc_pkg::RST_ANGLE_RECIP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ddmc_pkg::CSR_BASE_SPEED:      base_speed_ff      <= csr_data[7:0];
            ddmc_pkg::CSR_LINE_THRESHOLD:  line_threshold_ff  <= csr_data[7:0];
            ddmc_pkg::CSR_TURN_SLOWDOWN:   turn_slowdown_ff   <= csr_data[7:0];
            ddmc_pkg::CSR_LINE_CORRECTION: line_correction_ff <= csr_data[7:0];
            ddmc_pkg::CSR_DRIVE_STEP:      drive_step_ff      <= csr_data[7:0];
            ddmc_pkg::CSR_DISTANCE_RECIP:  distance_recip_ff  <= csr_data;
            ddmc_pkg::CSR_ANGLE_RECIP:     angle_recip_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Target calculation on the incoming request. The target depends only
   // on the request and the configuration, so the multiply sits in front
   // of the input register and the state update sees a ready target.
   // A soft turn (exactly one bridge bit set) doubles the angle.
   // ------------------------------------------------------------------
   logic        soft_turn;
   logic [16:0] mul_a;
   logic [15:0] mul_b;
   logic [32:0] mul_product;
   logic [15:0] target_calc;

   assign soft_turn = (req_wheel_dirs != 4'h0) &&
                      ((req_wheel_dirs & (req_wheel_dirs - 4'h1)) == 4'h0);

   always_comb begin
      if (req_func == ddmc_pkg::FUNC_TURN) begin
         mul_a = soft_turn ? {req_amount, 1'b0} : {1'b0, req_amount};
         mul_b = angle_recip_ff;
      end else begin
         mul_a = {1'b0, req_amount};
         mul_b = distance_recip_ff;
      end
      mul_product = {16'h0000, mul_a} * {17'h00000, mul_b};
      // Saturate the Q16 integer part to 16 bits.
      target_calc = mul_product[32] ? 16'hFFFF : mul_product[31:16];
   end

   // ------------------------------------------------------------------
   // Input register.
   // ------------------------------------------------------------------
   logic        in_valid_ff;
   logic [2:0]  in_func_ff;
   logic        in_left_edge_ff;
   logic        in_right_edge_ff;
   logic [3:0]  in_dirs_ff;
   logic [15:0] in_target_ff;
   logic [7:0]  in_left_level_ff;
   logic [7:0]  in_center_level_ff;
   logic [7:0]  in_right_level_ff;

   logic        rsp_valid_ff;
   logic        advance;

   // The request in the input register moves on when the result register
   // is empty or its contents are being taken this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff         <= req_func;
         in_left_edge_ff    <= req_left_edge;
         in_right_edge_ff   <= req_right_edge;
         in_dirs_ff         <= req_wheel_dirs;
         in_target_ff       <= target_calc;
         in_left_level_ff   <= req_left_level;
         in_center_level_ff <= req_center_level;
         in_right_level_ff  <= req_right_level;
      end
   end

   // ------------------------------------------------------------------
   // Controller state.
   // ------------------------------------------------------------------
   logic [31:0]        left_count_ff,   left_count_in;
   logic [31:0]        right_count_ff,  right_count_in;
   logic [7:0]         left_duty_ff,    left_duty_in;
   logic [7:0]         right_duty_ff,   right_duty_in;
   logic [15:0]        target_count_ff, target_count_in;
   ddmc_pkg::mode_type run_mode_ff,     run_mode_in;
   logic [3:0]         bridge_ff,       bridge_in;
   logic [15:0]        node_total_ff,   node_total_in;
   logic               done_in;

   logic        run_move;
   logic        run_turn;
   logic        run_line;
   logic        reached;
   logic [32:0] count_sum;
   logic        left_dark, center_dark, right_dark;
   logic        left_light, center_light, right_light;

   // Sensor thresholding: below the threshold a sensor sees the line (dark),
   // above it the sensor sees the floor (light); equal counts as neither.
   assign left_dark    = in_left_level_ff   < line_threshold_ff;
   assign center_dark  = in_center_level_ff < line_threshold_ff;
   assign right_dark   = in_right_level_ff  < line_threshold_ff;
   assign left_light   = in_left_level_ff   > line_threshold_ff;
   assign center_light = in_center_level_ff > line_threshold_ff;
   assign right_light  = in_right_level_ff  > line_threshold_ff;

   always_comb begin
      left_count_in   = left_count_ff;
      right_count_in  = right_count_ff;
      left_duty_in    = left_duty_ff;
      right_duty_in   = right_duty_ff;
      target_count_in = target_count_ff;
      run_mode_in     = run_mode_ff;
      bridge_in       = bridge_ff;
      node_total_in   = node_total_ff;
      done_in         = 1'b0;
      run_move        = 1'b0;
      run_turn        = 1'b0;
      run_line        = 1'b0;
      reached         = 1'b0;
      count_sum       = 33'h0;

      // Function decode. Encoder edges count on ticks only, whatever the mode.
      // A start abandons whatever was running.
      unique case (in_func_ff)
         ddmc_pkg::FUNC_TICK: begin
            if (in_left_edge_ff) begin
               left_count_in = left_count_ff + 32'd1;
            end
            if (in_right_edge_ff) begin
               right_count_in = right_count_ff + 32'd1;
            end
            run_move = (run_mode_ff == ddmc_pkg::MODE_MOVE);
            run_turn = (run_mode_ff == ddmc_pkg::MODE_TURN);
         end
         ddmc_pkg::FUNC_MOVE: begin
            left_count_in   = 32'h0;
            right_count_in  = 32'h0;
            bridge_in       = in_dirs_ff;
            target_count_in = in_target_ff;
            run_mode_in     = ddmc_pkg::MODE_MOVE;
            run_move        = 1'b1;
         end
         ddmc_pkg::FUNC_TURN: begin
            left_count_in   = 32'h0;
            right_count_in  = 32'h0;
            bridge_in       = in_dirs_ff;
            target_count_in = in_target_ff;
            run_mode_in     = ddmc_pkg::MODE_TURN;
            run_turn        = 1'b1;
         end
         ddmc_pkg::FUNC_LINE: begin
            left_duty_in  = base_speed_ff;
            right_duty_in = base_speed_ff;
            run_mode_in   = ddmc_pkg::MODE_LINE;
         end
         ddmc_pkg::FUNC_SAMPLE: begin
            run_line = (run_mode_ff == ddmc_pkg::MODE_LINE);
         end
         default: begin
         end
      endcase

      // Distance move: trim duties towards balanced counts, then test the mean.
      if (run_move) begin
         if (left_count_in == right_count_in) begin
            left_duty_in  = base_speed_ff;
            right_duty_in = base_speed_ff;
         end else if (left_count_in > right_count_in) begin
            right_duty_in = ddmc_pkg::sat_add(right_duty_ff, drive_step_ff);
            left_duty_in  = ddmc_pkg::sat_sub(left_duty_ff, drive_step_ff);
         end else begin
            right_duty_in = ddmc_pkg::sat_sub(right_duty_ff, drive_step_ff);
            left_duty_in  = ddmc_pkg::sat_add(left_duty_ff, drive_step_ff);
         end
         count_sum = {1'b0, left_count_in} + {1'b0, right_count_in};
         reached   = count_sum[32:1] >= {16'h0000, target_count_in};
      end

      // Turn: either wheel reaching the target ends it.
      if (run_turn) begin
         reached = (left_count_in  >= {16'h0000, target_count_in}) ||
                   (right_count_in >= {16'h0000, target_count_in});
      end

      if (reached) begin
         bridge_in   = ddmc_pkg::BRIDGE_STOP;
         run_mode_in = ddmc_pkg::MODE_IDLE;
         done_in     = 1'b1;
      end

      // Line sample while following the line.
      if (run_line) begin
         priority if (left_dark && center_dark && right_dark) begin
            // All three on the line: a crossing node, which ends line following.
            node_total_in = node_total_ff + 16'd1;
            run_mode_in   = ddmc_pkg::MODE_IDLE;
            done_in       = 1'b1;
         end else if (left_light && center_light && right_light) begin
            // Line lost: stop the bridge but stay in line mode.
            bridge_in = ddmc_pkg::BRIDGE_STOP;
         end else begin
            bridge_in = ddmc_pkg::BRIDGE_FORWARD;
            if (right_dark) begin
               left_duty_in  = base_speed_ff;
               right_duty_in = ddmc_pkg::sat_sub(base_speed_ff, turn_slowdown_ff);
            end
            if (left_dark) begin
               left_duty_in  = ddmc_pkg::sat_sub(base_speed_ff, turn_slowdown_ff);
               right_duty_in = base_speed_ff;
            end
            // Centre dark: lagging wheel up, other down from above; equal counts: base.
            if (center_dark) begin
               if (left_count_ff < right_count_ff) begin
                  left_duty_in  = ddmc_pkg::sat_add(left_duty_in, line_correction_ff);
                  right_duty_in = ddmc_pkg::sat_sub(right_duty_in, line_correction_ff);
               end else if (right_count_ff < left_count_ff) begin
                  left_duty_in  = ddmc_pkg::sat_sub(left_duty_in, line_correction_ff);
                  right_duty_in = ddmc_pkg::sat_add(right_duty_in, line_correction_ff);
               end else begin
                  left_duty_in  = base_speed_ff;
                  right_duty_in = base_speed_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff   <= 32'h0;
         right_count_ff  <= 32'h0;
         left_duty_ff    <= ddmc_pkg::RST_BASE_SPEED;
         right_duty_ff   <= ddmc_pkg::RST_BASE_SPEED;
         target_count_ff <= 16'h0;
         run_mode_ff     <= ddmc_pkg::MODE_IDLE;
         bridge_ff       <= ddmc_pkg::BRIDGE_STOP;
         node_total_ff   <= 16'h0;
      end else if (advance) begin
         left_count_ff   <= left_count_in;
         right_count_ff  <= right_count_in;
         left_duty_ff    <= left_duty_in;
         right_duty_ff   <= right_duty_in;
         target_count_ff <= target_count_in;
         run_mode_ff     <= run_mode_in;
         bridge_ff       <= bridge_in;
         node_total_ff   <= node_total_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   logic [3:0]  rsp_bridge_ff;
   logic [7:0]  rsp_left_pwm_ff;
   logic [7:0]  rsp_right_pwm_ff;
   logic        rsp_busy_ff;
   logic        rsp_done_ff;
   logic [15:0] rsp_nodes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bridge_ff    <= bridge_in;
         rsp_left_pwm_ff  <= left_duty_in;
         rsp_right_pwm_ff <= right_duty_in;
         rsp_busy_ff      <= (run_mode_in != ddmc_pkg::MODE_IDLE);
         rsp_done_ff      <= done_in;
         rsp_nodes_ff     <= node_total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bridge_bits = rsp_bridge_ff;
   assign rsp_left_pwm    = rsp_left_pwm_ff;
   assign rsp_right_pwm   = rsp_right_pwm_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_nodes_seen  = rsp_nodes_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // Every ending (target reached or node found) leaves the controller idle.
   `ASSERT_CLK(a_done_idle, clock, reset, (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff, "done result reports busy")

   // A request that cannot move on stays in the input register.
   `ASSERT_CLK(a_in_held, clock, reset, (in_valid_ff && !advance) |=> in_valid_ff, "request dropped from input register")

   // A request that moves on always produces a response.
   `ASSERT_CLK(a_adv_rsp, clock, reset, advance |=> rsp_valid_ff, "advanced request gave no response")

   // A move start either runs or finishes at once.
   `ASSERT_CLK(a_move_start, clock, reset, (advance && in_func_ff == ddmc_pkg::FUNC_MOVE) |=> (rsp_busy_ff || rsp_done_ff), "move start neither busy nor done")

endmodule

/* test/tb_differential_drive_motion_controller.sv */
`timescale 1ns / 1ps

// Self-checking bench for the two-wheel motion controller.
//
// Requests are queued by the stimulus process, presented by a driver that changes the
// inputs on the falling clock edge, and observed by a monitor on the rising edge. Every
// accepted request is run through a cycle-free model of the controller held in this
// bench. The model's answer is queued, and each response is compared with the oldest
// answer still waiting.
//
// The run has six phases. The first is a short directed walk through the special cases
// with the reset settings. The others load a fresh set of registers, the two extremes
// among them, and then play random traffic under one of several idling patterns. Register
// writes happen only once the controller has been fully drained.

module tb_differential_drive_motion_controller;

   localparam int CLOCK_PERIOD = 12;
   localparam int CYCLE_LIMIT  = 400000;

   // Function codes five to seven are spare and must leave the controller untouched.
   localparam logic [2:0] FUNC_SPARE_LOW  = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [2:0]  func;
      logic        left_edge;
      logic        right_edge;
      logic [15:0] amount;
      logic [3:0]  wheel_dirs;
      logic [7:0]  left_level;
      logic [7:0]  center_level;
      logic [7:0]  right_level;
   } request_type;

   typedef struct packed {
      logic [3:0]  bridge_bits;
      logic [7:0]  left_pwm;
      logic [7:0]  right_pwm;
      logic        busy_res;
      logic        done_res;
      logic [15:0] nodes_seen;
   } status_type;

   // Ports of the block under test. Every input holds a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = ddmc_pkg::FUNC_TICK;
   logic        req_left_edge = 1'b0;
   logic        req_right_edge = 1'b0;
   logic [15:0] req_amount = '0;
   logic [3:0]  req_wheel_dirs = '0;
   logic [7:0]  req_left_level = '0;
   logic [7:0]  req_center_level = '0;
   logic [7:0]  req_right_level = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_bridge_bits;
   logic [7:0]  rsp_left_pwm;
   logic [7:0]  rsp_right_pwm;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [15:0] rsp_nodes_seen;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Traffic bookkeeping.
   request_type queued_requests[$];
   status_type  predicted_status[$];
   request_type offer;
   request_type seen;
   status_type  answer;
   status_type  want;
   logic        req_taken = 1'b0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   logic [7:0]  plan_threshold = ddmc_pkg::RST_LINE_THRESHOLD;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned n_requests = 0;
   int unsigned n_moves = 0;
   int unsigned n_turns = 0;
   int unsigned n_samples = 0;
   int unsigned n_completions = 0;
   int unsigned n_writes = 0;

   // Shadow copy of the controller's registers and state.
   logic [7:0]  cfg_base;
   logic [7:0]  cfg_threshold;
   logic [7:0]  cfg_slowdown;
   logic [7:0]  cfg_correction;
   logic [7:0]  cfg_step;
   logic [15:0] cfg_dist_recip;
   logic [15:0] cfg_angle_recip;
   logic [31:0] odo_left;
   logic [31:0] odo_right;
   logic [7:0]  duty_left;
   logic [7:0]  duty_right;
   logic [15:0] goal_counts;
   ddmc_pkg::mode_type run_state;
   logic [3:0]  bridge_now;
   logic [15:0] crossings_tally;

   differential_drive_motion_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_left_edge    (req_left_edge),
      .req_right_edge   (req_right_edge),
      .req_amount       (req_amount),
      .req_wheel_dirs   (req_wheel_dirs),
      .req_left_level   (req_left_level),
      .req_center_level (req_center_level),
      .req_right_level  (req_right_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bridge_bits  (rsp_bridge_bits),
      .rsp_left_pwm     (rsp_left_pwm),
      .rsp_right_pwm    (rsp_right_pwm),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_nodes_seen   (rsp_nodes_seen),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Controller model
   // ---------------------------------------------------------------------------------

   // Duty values are clamped to the range of an 8-bit PWM compare value.
   function automatic logic [7:0] duty_plus(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = a + b;
      return (s > 9'd255) ? 8'd255 : s[7:0];
   endfunction

   function automatic logic [7:0] duty_minus(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : 8'd0;
   endfunction

   // Encoder counts to reach: the amount times a Q16 reciprocal, truncated, and held at
   // the 16-bit ceiling when a doubled soft-turn angle overshoots it.
   function automatic logic [15:0] scaled_target(input logic [16:0] amt,
                                                 input logic [15:0] recip);
      logic [32:0] prod;
      prod = (amt * recip) >> 16;
      return (prod > 33'd65535) ? 16'hFFFF : prod[15:0];
   endfunction

   // One step of a straight move: pull the duties toward the lagging wheel, or back to
   // the base speed when both wheels agree, and report whether the mean count has
   // reached the target.
   function automatic logic balance_wheels();
      if (odo_left == odo_right) begin
         duty_left  = cfg_base;
         duty_right = cfg_base;
      end else if (odo_left > odo_right) begin
         duty_right = duty_plus(duty_right, cfg_step);
         duty_left  = duty_minus(duty_left, cfg_step);
      end else begin
         duty_right = duty_minus(duty_right, cfg_step);
         duty_left  = duty_plus(duty_left, cfg_step);
      end
      return (({1'b0, odo_left} + {1'b0, odo_right}) >> 1) >= {17'd0, goal_counts};
   endfunction

   task automatic restore_defaults();
      cfg_base        = ddmc_pkg::RST_BASE_SPEED;
      cfg_threshold   = ddmc_pkg::RST_LINE_THRESHOLD;
      cfg_slowdown    = ddmc_pkg::RST_TURN_SLOWDOWN;
      cfg_correction  = ddmc_pkg::RST_LINE_CORRECTION;
      cfg_step        = ddmc_pkg::RST_DRIVE_STEP;
      cfg_dist_recip  = ddmc_pkg::RST_DISTANCE_RECIP;
      cfg_angle_recip = ddmc_pkg::RST_ANGLE_RECIP;
      odo_left        = '0;
      odo_right       = '0;
      duty_left       = ddmc_pkg::RST_BASE_SPEED;
      duty_right      = ddmc_pkg::RST_BASE_SPEED;
      goal_counts     = '0;
      run_state       = ddmc_pkg::MODE_IDLE;
      bridge_now      = ddmc_pkg::BRIDGE_STOP;
      crossings_tally = '0;
   endtask

   // Applies one request to the shadow state and returns the status it should produce.
   task automatic advance_controller(input request_type r, output status_type res);
      logic done;
      logic single_wheel;
      logic l_dark, c_dark, r_dark;
      logic l_light, c_light, r_light;
      done = 1'b0;
      case (r.func)
         ddmc_pkg::FUNC_TICK: begin
            // Edges are counted in every mode, idle included.
            if (r.left_edge) odo_left = odo_left + 32'd1;
            if (r.right_edge) odo_right = odo_right + 32'd1;
            if (run_state == ddmc_pkg::MODE_MOVE) done = balance_wheels();
            else if (run_state == ddmc_pkg::MODE_TURN)
               done = (odo_left >= {16'd0, goal_counts}) ||
                      (odo_right >= {16'd0, goal_counts});
         end
         ddmc_pkg::FUNC_MOVE: begin
            odo_left    = '0;
            odo_right   = '0;
            bridge_now  = r.wheel_dirs;
            goal_counts = scaled_target({1'b0, r.amount}, cfg_dist_recip);
            run_state   = ddmc_pkg::MODE_MOVE;
            duty_left   = cfg_base;
            duty_right  = cfg_base;
            done        = balance_wheels();
         end
         ddmc_pkg::FUNC_TURN: begin
            // A single set direction bit means one wheel stands still, so the arc is
            // twice as long for the same heading change.
            single_wheel = (r.wheel_dirs == 4'h1) || (r.wheel_dirs == 4'h2) ||
                           (r.wheel_dirs == 4'h4) || (r.wheel_dirs == 4'h8);
            odo_left    = '0;
            odo_right   = '0;
            bridge_now  = r.wheel_dirs;
            goal_counts = scaled_target(single_wheel ? {r.amount, 1'b0}
                                                     : {1'b0, r.amount},
                                        cfg_angle_recip);
            run_state   = ddmc_pkg::MODE_TURN;
            done        = (goal_counts == 16'd0);
         end
         ddmc_pkg::FUNC_LINE: begin
            duty_left  = cfg_base;
            duty_right = cfg_base;
            run_state  = ddmc_pkg::MODE_LINE;
         end
         ddmc_pkg::FUNC_SAMPLE: begin
            if (run_state == ddmc_pkg::MODE_LINE) begin
               l_dark  = r.left_level < cfg_threshold;
               c_dark  = r.center_level < cfg_threshold;
               r_dark  = r.right_level < cfg_threshold;
               l_light = r.left_level > cfg_threshold;
               c_light = r.center_level > cfg_threshold;
               r_light = r.right_level > cfg_threshold;
               if (l_dark && c_dark && r_dark) begin
                  // A crossing line: count it and stop following, bridge untouched.
                  crossings_tally = crossings_tally + 16'd1;
                  run_state       = ddmc_pkg::MODE_IDLE;
                  done            = 1'b1;
               end else if (l_light && c_light && r_light) begin
                  bridge_now = ddmc_pkg::BRIDGE_STOP;
               end else begin
                  bridge_now = ddmc_pkg::BRIDGE_FORWARD;
                  if (r_dark) begin
                     duty_left  = cfg_base;
                     duty_right = duty_minus(cfg_base, cfg_slowdown);
                  end
                  if (l_dark) begin
                     duty_left  = duty_minus(cfg_base, cfg_slowdown);
                     duty_right = cfg_base;
                  end
                  if (c_dark) begin
                     if (odo_left < odo_right) begin
                        duty_left  = duty_plus(duty_left, cfg_correction);
                        duty_right = duty_minus(duty_right, cfg_correction);
                     end else if (odo_right < odo_left) begin
                        duty_left  = duty_minus(duty_left, cfg_correction);
                        duty_right = duty_plus(duty_right, cfg_correction);
                     end else begin
                        duty_left  = cfg_base;
                        duty_right = cfg_base;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      // A finished move or turn stops the bridge; a found node leaves it running.
      if (done && r.func != ddmc_pkg::FUNC_SAMPLE) begin
         bridge_now = ddmc_pkg::BRIDGE_STOP;
         run_state  = ddmc_pkg::MODE_IDLE;
      end
      res.bridge_bits = bridge_now;
      res.left_pwm    = duty_left;
      res.right_pwm   = duty_right;
      res.busy_res    = (run_state != ddmc_pkg::MODE_IDLE);
      res.done_res    = done;
      res.nodes_seen  = crossings_tally;
   endtask

   // ---------------------------------------------------------------------------------
   // Driver and monitor
   // ---------------------------------------------------------------------------------

   // The driver works on the falling edge. A request stays on the bus until the monitor
   // has seen it accepted, and only then may the next one take its place.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            offer = queued_requests.pop_front();
            req_func         <= offer.func;
            req_left_edge    <= offer.left_edge;
            req_right_edge   <= offer.right_edge;
            req_amount       <= offer.amount;
            req_wheel_dirs   <= offer.wheel_dirs;
            req_left_level   <= offer.left_level;
            req_center_level <= offer.center_level;
            req_right_level  <= offer.right_level;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The monitor samples on the rising edge, before the block's registers move.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ddmc_pkg::CSR_BASE_SPEED:      cfg_base        = csr_data[7:0];
               ddmc_pkg::CSR_LINE_THRESHOLD:  cfg_threshold   = csr_data[7:0];
               ddmc_pkg::CSR_TURN_SLOWDOWN:   cfg_slowdown    = csr_data[7:0];
               ddmc_pkg::CSR_LINE_CORRECTION: cfg_correction  = csr_data[7:0];
               ddmc_pkg::CSR_DRIVE_STEP:      cfg_step        = csr_data[7:0];
               ddmc_pkg::CSR_DISTANCE_RECIP:  cfg_dist_recip  = csr_data;
               ddmc_pkg::CSR_ANGLE_RECIP:     cfg_angle_recip = csr_data;
               default: ;
            endcase
            n_writes++;
         end

         if (rsp_valid && rsp_ready) begin
            if (predicted_status.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatches++;
            end else begin
               want = predicted_status.pop_front();
               if (rsp_bridge_bits !== want.bridge_bits) begin
                  $error("bridge_bits: expected %0h, got %0h", want.bridge_bits,
                         rsp_bridge_bits);
                  mismatches++;
               end
               if (rsp_left_pwm !== want.left_pwm) begin
                  $error("left_pwm: expected %0d, got %0d", want.left_pwm, rsp_left_pwm);
                  mismatches++;
               end
               if (rsp_right_pwm !== want.right_pwm) begin
                  $error("right_pwm: expected %0d, got %0d", want.right_pwm, rsp_right_pwm);
                  mismatches++;
               end
               if (rsp_busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0b, got %0b", want.busy_res, rsp_busy_res);
                  mismatches++;
               end
               if (rsp_done_res !== want.done_res) begin
                  $error("done_res: expected %0b, got %0b", want.done_res, rsp_done_res);
                  mismatches++;
               end
               if (rsp_nodes_seen !== want.nodes_seen) begin
                  $error("nodes_seen: expected %0d, got %0d", want.nodes_seen,
                         rsp_nodes_seen);
                  mismatches++;
               end
            end
         end

         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            seen.func         = req_func;
            seen.left_edge    = req_left_edge;
            seen.right_edge   = req_right_edge;
            seen.amount       = req_amount;
            seen.wheel_dirs   = req_wheel_dirs;
            seen.left_level   = req_left_level;
            seen.center_level = req_center_level;
            seen.right_level  = req_right_level;
            advance_controller(seen, answer);
            predicted_status.push_back(answer);
            n_requests++;
            if (req_func == ddmc_pkg::FUNC_MOVE) n_moves++;
            if (req_func == ddmc_pkg::FUNC_TURN) n_turns++;
            if (req_func == ddmc_pkg::FUNC_SAMPLE) n_samples++;
            if (answer.done_res) n_completions++;
         end
      end
   end

   // Watchdog: a hung handshake must not hold the run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------

   function automatic request_type make_req(input logic [2:0] func, input logic le,
                                            input logic re, input logic [15:0] amount,
                                            input logic [3:0] dirs, input logic [7:0] lv,
                                            input logic [7:0] cv, input logic [7:0] rv);
      request_type q;
      q.func         = func;
      q.left_edge    = le;
      q.right_edge   = re;
      q.amount       = amount;
      q.wheel_dirs   = dirs;
      q.left_level   = lv;
      q.center_level = cv;
      q.right_level  = rv;
      return q;
   endfunction

   function automatic request_type random_request();
      request_type q;
      q.func         = 3'($urandom_range(0, 7));
      q.left_edge    = 1'($urandom_range(0, 1));
      q.right_edge   = 1'($urandom_range(0, 1));
      q.amount       = 16'($urandom_range(0, 65535));
      q.wheel_dirs   = 4'($urandom_range(0, 15));
      q.left_level   = 8'($urandom_range(0, 255));
      q.center_level = 8'($urandom_range(0, 255));
      q.right_level  = 8'($urandom_range(0, 255));
      return q;
   endfunction

   // Sensor levels are drawn around the threshold so that dark, light and the exact
   // threshold value, which counts as neither, all turn up often.
   function automatic logic [7:0] pick_level(input logic [7:0] th);
      case ($urandom_range(0, 3))
         0: return th;
         1: return (th == 8'd0) ? 8'd0 : 8'($urandom_range(0, th - 1));
         2: return (th == 8'd255) ? 8'd255 : 8'($urandom_range(th + 1, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [7:0] base, input logic [7:0] th,
                                input logic [7:0] slow, input logic [7:0] corr,
                                input logic [7:0] step, input logic [15:0] drecip,
                                input logic [15:0] arecip);
      write_register(ddmc_pkg::CSR_BASE_SPEED, {8'd0, base});
      write_register(ddmc_pkg::CSR_LINE_THRESHOLD, {8'd0, th});
      write_register(ddmc_pkg::CSR_TURN_SLOWDOWN, {8'd0, slow});
      write_register(ddmc_pkg::CSR_LINE_CORRECTION, {8'd0, corr});
      write_register(ddmc_pkg::CSR_DRIVE_STEP, {8'd0, step});
      write_register(ddmc_pkg::CSR_DISTANCE_RECIP, drecip);
      write_register(ddmc_pkg::CSR_ANGLE_RECIP, arecip);
      plan_threshold = th;
   endtask

   // Holds the stimulus back until every queued request has been answered, then lets
   // the two-stage pipeline settle before anything else happens.
   task automatic wait_drained();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_valid || predicted_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Random traffic is built mostly from well-formed episodes: a start request followed
   // by a burst of ticks or line samples. Each wheel gets its own edge rate per episode
   // so that the counts drift apart. A share of the episodes is pure noise, which also
   // produces starts that cut a running operation short.
   task automatic queue_random_traffic(input int unsigned quota);
      int unsigned made;
      int unsigned kind;
      int unsigned span;
      int unsigned k;
      int unsigned rate_l;
      int unsigned rate_r;
      request_type q;
      made = 0;
      while (made < quota) begin
         kind   = $urandom_range(0, 9);
         span   = $urandom_range(1, 40);
         rate_l = $urandom_range(30, 100);
         rate_r = $urandom_range(30, 100);
         q = random_request();
         if (kind <= 2) begin
            q.func = ddmc_pkg::FUNC_MOVE;
            if ($urandom_range(0, 9) != 0) q.amount = 16'($urandom_range(0, 40));
         end else if (kind <= 4) begin
            q.func = ddmc_pkg::FUNC_TURN;
            if ($urandom_range(0, 9) != 0) q.amount = 16'($urandom_range(0, 30));
            if ($urandom_range(0, 1) != 0) q.wheel_dirs = 4'h1 << $urandom_range(0, 3);
         end else begin
            q.func = ddmc_pkg::FUNC_LINE;
         end
         if (kind <= 7) begin
            queued_requests.push_back(q);
            made++;
         end
         for (k = 0; k < span; k++) begin
            q = random_request();
            if (kind <= 4) begin
               q.func       = ddmc_pkg::FUNC_TICK;
               q.left_edge  = ($urandom_range(1, 100) <= rate_l);
               q.right_edge = ($urandom_range(1, 100) <= rate_r);
            end else if (kind <= 7) begin
               if ($urandom_range(0, 4) == 0) begin
                  q.func = ddmc_pkg::FUNC_TICK;
               end else begin
                  q.func         = ddmc_pkg::FUNC_SAMPLE;
                  q.left_level   = pick_level(plan_threshold);
                  q.center_level = pick_level(plan_threshold);
                  q.right_level  = pick_level(plan_threshold);
               end
            end
            queued_requests.push_back(q);
            if (q.func < FUNC_SPARE_LOW) made++;
         end
      end
   endtask

   task automatic queue_directed_walk();
      // Edges are counted even while idle; spare codes and stray samples do nothing.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 1, 1, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(FUNC_SPARE_HIGH, 1, 1, 16'hFFFF, 4'hF,
                                         8'hFF, 8'hFF, 8'hFF));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
      // A zero-length move completes on its own start request.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_MOVE, 0, 0, 0,
                                         ddmc_pkg::BRIDGE_FORWARD, 0, 0, 0));
      // The longest move, steered by one wheel running ahead and then the other.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_MOVE, 0, 0, 16'hFFFF, 4'hF,
                                         0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 1, 0, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 0, 1, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 0, 1, 0, 0, 0, 0, 0));
      // A zero-angle turn completes at once; a soft turn doubles a short angle.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TURN, 0, 0, 0, 4'h0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TURN, 0, 0, 16'd5, 4'h8,
                                         0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 1, 0, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 1, 0, 0, 0, 0, 0, 0));
      // Each start below but the first cuts short the operation that the one before began.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TURN, 0, 0, 16'hFFFF, 4'h1,
                                         0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_MOVE, 0, 0, 16'd100,
                                         ddmc_pkg::BRIDGE_FORWARD, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_LINE, 0, 0, 0, 0, 0, 0, 0));
      // All three sensors dark is a node, after which samples are ignored.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         255, 255, 255));
      // Line following: all light, each single sensor dark, a wheel ahead on either
      // side, and levels sitting exactly on the threshold.
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_LINE, 0, 0, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         255, 255, 255));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         255, 255, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         0, 255, 255));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         255, 0, 255));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 1, 0, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         255, 0, 255));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0,
                                         ddmc_pkg::RST_LINE_THRESHOLD,
                                         ddmc_pkg::RST_LINE_THRESHOLD,
                                         ddmc_pkg::RST_LINE_THRESHOLD));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 0, 1, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_TICK, 0, 1, 0, 0, 0, 0, 0));
      queued_requests.push_back(make_req(ddmc_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 255));
      queued_requests.push_back(make_req(FUNC_SPARE_LOW, 0, 0, 0, 0, 0, 0, 0));
   endtask

   initial begin
      restore_defaults();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk with the reset settings and no idling on either side.
      queue_directed_walk();
      wait_drained();

      // Every register at its ceiling, steady traffic.
      load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
      queue_random_traffic(265);
      wait_drained();

      // Every register at zero: all targets collapse and no sensor can read dark.
      sender_idle_pct = 62;
      load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
      queue_random_traffic(180);
      wait_drained();

      // A random set of values with a stalling receiver.
      sender_idle_pct    = 0;
      receiver_stall_pct = 62;
      load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(100, 240)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)),
                    8'($urandom_range(0, 40)), 16'($urandom_range(4000, 30000)),
                    16'($urandom_range(4000, 30000)));
      queue_random_traffic(290);
      wait_drained();

      // Back to the reset values, with both sides idling.
      sender_idle_pct    = 22;
      receiver_stall_pct = 22;
      load_settings(ddmc_pkg::RST_BASE_SPEED, ddmc_pkg::RST_LINE_THRESHOLD,
                    ddmc_pkg::RST_TURN_SLOWDOWN, ddmc_pkg::RST_LINE_CORRECTION,
                    ddmc_pkg::RST_DRIVE_STEP, ddmc_pkg::RST_DISTANCE_RECIP,
                    ddmc_pkg::RST_ANGLE_RECIP);
      queue_random_traffic(290);
      wait_drained();

      // A second random set with the sender idling.
      sender_idle_pct    = 62;
      receiver_stall_pct = 0;
      load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
      queue_random_traffic(270);
      wait_drained();

      $display("Run covered %0d requests: %0d moves, %0d turns, %0d line samples.",
               n_requests, n_moves, n_turns, n_samples);
      $display("It saw %0d completions, %0d nodes and %0d register writes.",
               n_completions, crossings_tally, n_writes);
      if (mismatches == 0 && predicted_status.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
